// File: rtl/dspv_pkg.sv
// ----------------------------------------------------------------------------
// dspv_pkg
// Shared types and constants for the date string parse and validate core.
// ----------------------------------------------------------------------------
package dspv_pkg;

  // which field of the text is being read
  typedef enum logic [1:0] {
    FIELD_DAY   = 2'd0,
    FIELD_MONTH = 2'd1,
    FIELD_YEAR  = 2'd2
  } field_t;

  // scanning phase inside one field
  typedef enum logic [1:0] {
    PHASE_BLANK  = 2'd0,
    PHASE_DIGITS = 2'd1,
    PHASE_IGNORE = 2'd2
  } phase_t;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // saturation limits
  localparam logic [7:0]  SMALL_MAX = 8'd255;
  localparam logic [15:0] YEAR_MAX  = 16'd65535;

  // calendar constants
  localparam logic [8:0] GREG_CYCLE  = 9'd400;
  localparam logic [8:0] CENTURY_1   = 9'd100;
  localparam logic [8:0] CENTURY_2   = 9'd200;
  localparam logic [8:0] CENTURY_3   = 9'd300;
  localparam logic [7:0] DAYS_LONG   = 8'd31;
  localparam logic [7:0] DAYS_SHORT  = 8'd30;
  localparam logic [7:0] DAYS_FEB_LP = 8'd29;
  localparam logic [7:0] DAYS_FEB    = 8'd28;
  localparam logic [7:0] MONTH_FEB   = 8'd2;
  localparam logic [7:0] MONTH_APR   = 8'd4;
  localparam logic [7:0] MONTH_JUN   = 8'd6;
  localparam logic [7:0] MONTH_SEP   = 8'd9;
  localparam logic [7:0] MONTH_NOV   = 8'd11;
  localparam logic [7:0] MONTH_DEC   = 8'd12;

endpackage

// File: rtl/date_string_parse_validate_core.sv
// ----------------------------------------------------------------------------
// date_string_parse_validate_core
// Parses a "D.M.Y" text one byte per item and checks the Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_char_in carries one text byte per item; a zero byte
//   ends the string. Every other byte only updates the parse state.
//   out_valid/out_ready carries one result item per zero byte: out_date_ok
//   plus day, month and year (all zero when the date is not valid).
// Timing:
//   one byte is taken per cycle while in_ready is high; the parse state updates at the accept edge.
//   The result of a zero byte is loaded into the output register at its
//   accept edge.
//   The per-byte path is one multiply by ten with add and saturation plus a
//   four step conditional subtract that keeps the year mod 400.
// Stall:
//   while a result waits in the output register and out_ready is low, no
//   byte is taken; the byte arriving with out_ready high is taken at once.
// Reset:
//   rst_n (synchronous, active low) clears the parse state and drops
//   out_valid. A zero byte also returns the parser to its reset state.
// ----------------------------------------------------------------------------
module date_string_parse_validate_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_date_ok,
  output logic [4:0]  out_day_out,
  output logic [3:0]  out_month_out,
  output logic [15:0] out_year_out
);
  import dspv_pkg::*;

  // parse state
  field_t      field_r,     field_nxt;
  phase_t      phase_r,     phase_nxt;
  logic        neg_r,       neg_nxt;
  logic [7:0]  day_r,       day_nxt;
  logic [7:0]  month_r,     month_nxt;
  logic        day_neg_r,   day_neg_nxt;
  logic        month_neg_r, month_neg_nxt;
  logic [15:0] year_r,      year_nxt;
  logic [8:0]  ymod_r,      ymod_nxt;
  logic        yovf_r,      yovf_nxt;

  // result register
  logic        out_valid_r;
  logic        ok_r;
  logic [4:0]  day_out_r;
  logic [3:0]  month_out_r;
  logic [15:0] year_out_r;

  logic        in_acc;
  logic        is_end, is_dot_sep, is_blank, is_sign, is_digit, push;
  logic [3:0]  digit;
  logic [7:0]  sel_small;
  logic [11:0] small_sum;
  logic [7:0]  small_sat;
  logic [19:0] year_sum;
  logic [11:0] mod_s0, mod_s1, mod_s2, mod_s3, mod_s4;
  logic        leap, date_ok;
  logic [7:0]  month_len;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // byte classes
  assign is_end     = (in_char_in == CH_NUL);
  assign is_dot_sep = (in_char_in == CH_DOT) && (field_r != FIELD_YEAR);
  assign is_blank   = (in_char_in == CH_SPACE) ||
                      ((in_char_in >= CH_TAB) && (in_char_in <= CH_CR));
  assign is_sign    = (in_char_in == CH_PLUS) || (in_char_in == CH_MINUS);
  assign is_digit   = (in_char_in >= CH_ZERO) && (in_char_in <= CH_NINE);
  assign digit      = 4'(in_char_in - CH_ZERO);
  assign push       = is_digit && ((phase_r == PHASE_BLANK) || (phase_r == PHASE_DIGITS));

  // day or month accumulate, saturating at 255
  assign sel_small = (field_r == FIELD_DAY) ? day_r : month_r;
  assign small_sum = 12'(sel_small) * 12'd10 + 12'(digit);
  assign small_sat = (small_sum > 12'(SMALL_MAX)) ? SMALL_MAX : small_sum[7:0];

  // year accumulate, saturating at 65535
  assign year_sum = 20'(year_r) * 20'd10 + 20'(digit);

  // year mod 400 by binary conditional subtract (value below 4000)
  assign mod_s0 = 12'(ymod_r) * 12'd10 + 12'(digit);
  assign mod_s1 = (mod_s0 >= 12'(GREG_CYCLE) * 12'd8) ? mod_s0 - 12'(GREG_CYCLE) * 12'd8 : mod_s0;
  assign mod_s2 = (mod_s1 >= 12'(GREG_CYCLE) * 12'd4) ? mod_s1 - 12'(GREG_CYCLE) * 12'd4 : mod_s1;
  assign mod_s3 = (mod_s2 >= 12'(GREG_CYCLE) * 12'd2) ? mod_s2 - 12'(GREG_CYCLE) * 12'd2 : mod_s2;
  assign mod_s4 = (mod_s3 >= 12'(GREG_CYCLE)) ? mod_s3 - 12'(GREG_CYCLE) : mod_s3;

  // next parse state
  always_comb begin
    field_nxt     = field_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    day_neg_nxt   = day_neg_r;
    month_neg_nxt = month_neg_r;
    year_nxt      = year_r;
    ymod_nxt      = ymod_r;
    yovf_nxt      = yovf_r;
    if (is_end) begin
      field_nxt     = FIELD_DAY;
      phase_nxt     = PHASE_BLANK;
      neg_nxt       = 1'b0;
      day_nxt       = '0;
      month_nxt     = '0;
      day_neg_nxt   = 1'b0;
      month_neg_nxt = 1'b0;
      year_nxt      = '0;
      ymod_nxt      = '0;
      yovf_nxt      = 1'b0;
    end else if (is_dot_sep) begin
      if (field_r == FIELD_DAY) begin
        day_neg_nxt = neg_r && (day_r != '0);
        field_nxt   = FIELD_MONTH;
      end else begin
        month_neg_nxt = neg_r && (month_r != '0);
        field_nxt     = FIELD_YEAR;
      end
      phase_nxt = PHASE_BLANK;
      neg_nxt   = 1'b0;
    end else begin
      // phase walk
      case (phase_r)
        PHASE_BLANK: begin
          if (is_blank) begin
            phase_nxt = PHASE_BLANK;
          end else if (is_sign) begin
            neg_nxt   = (in_char_in == CH_MINUS);
            phase_nxt = PHASE_DIGITS;
          end else if (is_digit) begin
            phase_nxt = PHASE_DIGITS;
          end else begin
            phase_nxt = PHASE_IGNORE;
          end
        end
        PHASE_DIGITS: begin
          if (!is_digit) begin
            phase_nxt = PHASE_IGNORE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
      // digit push into the current field
      if (push) begin
        case (field_r)
          FIELD_DAY:   day_nxt = small_sat;
          FIELD_MONTH: month_nxt = small_sat;
          default: begin
            if (year_sum > 20'(YEAR_MAX)) begin
              year_nxt = YEAR_MAX;
              yovf_nxt = 1'b1;
            end else begin
              year_nxt = year_sum[15:0];
            end
            ymod_nxt = mod_s4[8:0];
          end
        endcase
      end
    end
  end

  // leap rule on year mod 400
  assign leap = ((ymod_r[1:0] == 2'b00) && (ymod_r != CENTURY_1) &&
                 (ymod_r != CENTURY_2) && (ymod_r != CENTURY_3)) ||
                (ymod_r == '0);

  // month length
  always_comb begin
    if (month_r == MONTH_FEB) begin
      month_len = leap ? DAYS_FEB_LP : DAYS_FEB;
    end else if ((month_r == MONTH_APR) || (month_r == MONTH_JUN) ||
                 (month_r == MONTH_SEP) || (month_r == MONTH_NOV)) begin
      month_len = DAYS_SHORT;
    end else begin
      month_len = DAYS_LONG;
    end
  end

  // full validity check
  assign date_ok = (field_r == FIELD_YEAR) && !day_neg_r && !month_neg_r &&
                   (day_r != '0) && (day_r <= month_len) &&
                   (month_r != '0) && (month_r <= MONTH_DEC) &&
                   !(neg_r && (year_r != '0)) && !yovf_r;

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r     <= FIELD_DAY;
      phase_r     <= PHASE_BLANK;
      neg_r       <= 1'b0;
      day_r       <= '0;
      month_r     <= '0;
      day_neg_r   <= 1'b0;
      month_neg_r <= 1'b0;
      year_r      <= '0;
      ymod_r      <= '0;
      yovf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        field_r     <= field_nxt;
        phase_r     <= phase_nxt;
        neg_r       <= neg_nxt;
        day_r       <= day_nxt;
        month_r     <= month_nxt;
        day_neg_r   <= day_neg_nxt;
        month_neg_r <= month_neg_nxt;
        year_r      <= year_nxt;
        ymod_r      <= ymod_nxt;
        yovf_r      <= yovf_nxt;
      end
      if (in_acc && is_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each end-of-string item
  always_ff @(posedge clk) begin
    if (in_acc && is_end) begin
      ok_r        <= date_ok;
      day_out_r   <= date_ok ? day_r[4:0] : '0;
      month_out_r <= date_ok ? month_r[3:0] : '0;
      year_out_r  <= date_ok ? year_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_date_ok   = ok_r;
  assign out_day_out   = day_out_r;
  assign out_month_out = month_out_r;
  assign out_year_out  = year_out_r;

endmodule
